@@ rtl/pws_pkg.sv @@
// Shared types and constants for the pan window smoother.
package pws_pkg;

    // Defaults for the top level parameters
    localparam int HISTORY_DEPTH_DEF = 3;
    localparam int COORD_BITS_DEF    = 13;

    // 0.04 of the width and the target spread test both compare as 25*d < w
    localparam int ZONE_SCALE  = 25;
    // Frames in the stop zone before movement is dropped
    localparam int STOP_FRAMES = 4;
    // Floor on the maximum speed
    localparam int MIN_SPEED   = 3;

    typedef enum logic [1:0] {
        LOCK_NONE  = 2'd0,
        LOCK_LEFT  = 2'd1,
        LOCK_RIGHT = 2'd2
    } lock_t;

endpackage

@@ rtl/pws_history.sv @@
// Target x history and the holding test on its spread.
module pws_history #(
    parameter int HISTORY_DEPTH = pws_pkg::HISTORY_DEPTH_DEF,
    parameter int COORD_BITS    = pws_pkg::COORD_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic [COORD_BITS-1:0] target_x,
    input  logic [COORD_BITS-1:0] target_width,
    output logic                  holding
);
    import pws_pkg::*;

    localparam int SLOT_BITS = $clog2(HISTORY_DEPTH);
    localparam int PROD_BITS = COORD_BITS + 5;

    logic [COORD_BITS-1:0]    hist_reg  [HISTORY_DEPTH];
    logic [COORD_BITS-1:0]    hist_next [HISTORY_DEPTH];
    logic [HISTORY_DEPTH-1:0] valid_reg;
    logic [HISTORY_DEPTH-1:0] valid_next;
    logic [SLOT_BITS-1:0]     slot_reg;
    logic [SLOT_BITS-1:0]     slot_next;
    logic [COORD_BITS-1:0]    lo;
    logic [COORD_BITS-1:0]    hi;
    logic [PROD_BITS-1:0]     spread_scaled;

    always_comb
    begin
        for (int i = 0; i < HISTORY_DEPTH; i++)
        begin
            hist_next[i]  = (slot_reg == SLOT_BITS'(i)) ? target_x : hist_reg[i];
            valid_next[i] = valid_reg[i] | (slot_reg == SLOT_BITS'(i));
        end
        slot_next = (slot_reg == SLOT_BITS'(HISTORY_DEPTH - 1)) ? '0 : slot_reg + 1'b1;
    end

    always_comb
    begin
        lo = hist_next[0];
        hi = hist_next[0];
        for (int i = 1; i < HISTORY_DEPTH; i++)
        begin
            if (hist_next[i] < lo)
            begin
                lo = hist_next[i];
            end
            if (hist_next[i] > hi)
            begin
                hi = hist_next[i];
            end
        end
        spread_scaled = PROD_BITS'(hi - lo) * PROD_BITS'(ZONE_SCALE);
        holding = (&valid_next) && (spread_scaled < PROD_BITS'(target_width));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            slot_reg  <= '0;
        end
        else if (en)
        begin
            valid_reg <= valid_next;
            slot_reg  <= slot_next;
        end
    end

    // Entries are only read once every valid bit is set
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < HISTORY_DEPTH; i++)
            begin
                hist_reg[i] <= hist_next[i];
            end
        end
    end

endmodule

@@ rtl/pws_pan.sv @@
// Speed ramp, stop zone and direction lock giving the next window x.
module pws_pan #(
    parameter int COORD_BITS = pws_pkg::COORD_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic [COORD_BITS-1:0] cur_x,
    input  logic [COORD_BITS-1:0] cur_width,
    input  logic [COORD_BITS-1:0] target_x,
    input  logic                  holding,
    output logic [COORD_BITS-1:0] next_x
);
    import pws_pkg::*;

    // Speeds never exceed the larger of x_dist/24 and MIN_SPEED, so four bits fewer than a coordinate
    localparam int SPD_BITS  = COORD_BITS - 4;
    // x_dist/24 as (x_dist>>3)/3 by reciprocal
    localparam int Q3_BITS   = COORD_BITS - 3;
    localparam int S3        = Q3_BITS + 2;
    localparam int M3        = ((32'd1 << S3) + 2) / 3;
    localparam int P3_BITS   = 2 * Q3_BITS + 1;
    // diff/100 as (diff>>2)/25 by reciprocal
    localparam int Q25_BITS  = SPD_BITS - 2;
    localparam int S25       = Q25_BITS + 5;
    localparam int M25       = ((32'd1 << S25) + 24) / 25;
    localparam int P25_BITS  = 2 * Q25_BITS + 1;
    localparam int ZONE_BITS = COORD_BITS + 5;

    logic [SPD_BITS-1:0]   last_speed_reg;
    logic [SPD_BITS-1:0]   last_speed_next;
    logic [2:0]            stop_count_reg;
    logic [2:0]            stop_count_next;
    lock_t                 lock_reg;
    lock_t                 lock_next;

    logic [COORD_BITS-1:0] x_dist;
    logic                  far;
    logic                  in_zone;
    logic [P3_BITS-1:0]    prod3;
    logic [SPD_BITS-1:0]   max_raw;
    logic [SPD_BITS-1:0]   max_speed;
    logic [SPD_BITS-1:0]   diff;
    logic [P25_BITS-1:0]   prod25;
    logic [SPD_BITS-1:0]   step_q;
    logic [SPD_BITS-1:0]   step;
    logic [SPD_BITS-1:0]   speed;
    logic [2:0]            stop_inc;
    lock_t                 lock_open;
    logic [COORD_BITS:0]   right_sum;
    logic [COORD_BITS-1:0] speed_c;

    always_comb
    begin
        x_dist  = (cur_x > target_x) ? cur_x - target_x : target_x - cur_x;
        far     = !({x_dist, 1'b0} < {1'b0, cur_width});
        in_zone = (ZONE_BITS'(x_dist) * ZONE_BITS'(ZONE_SCALE)) < ZONE_BITS'(cur_width);

        prod3   = P3_BITS'(x_dist[COORD_BITS-1:3]) * P3_BITS'(M3);
        max_raw = SPD_BITS'(prod3 >> S3);
        max_speed = (max_raw < SPD_BITS'(MIN_SPEED)) ? SPD_BITS'(MIN_SPEED) : max_raw;

        diff    = max_speed - last_speed_reg;
        prod25  = P25_BITS'(diff[SPD_BITS-1:2]) * P25_BITS'(M25);
        step_q  = SPD_BITS'(prod25 >> S25);
        step    = (step_q < SPD_BITS'(2)) ? SPD_BITS'(1) : step_q;
        speed   = (last_speed_reg < max_speed) ? last_speed_reg + step : max_speed;
        speed_c = COORD_BITS'(speed);

        stop_inc  = (stop_count_reg < 3'(STOP_FRAMES)) ? stop_count_reg + 3'd1
                                                      : stop_count_reg;
        lock_open = far ? LOCK_NONE : lock_reg;
        right_sum = {1'b0, cur_x} + {1'b0, speed_c};
    end

    always_comb
    begin
        next_x          = cur_x;
        last_speed_next = last_speed_reg;
        stop_count_next = stop_count_reg;
        lock_next       = lock_reg;
        if (!far && last_speed_reg == '0)
        begin
            // Idle and close enough: stay put
        end
        else if (in_zone && last_speed_reg != '0)
        begin
            stop_count_next = stop_inc;
            lock_next       = lock_open;
            if (stop_inc > 3'(STOP_FRAMES - 1) || holding)
            begin
                lock_next       = LOCK_NONE;
                last_speed_next = '0;
            end
        end
        else
        begin
            stop_count_next = '0;
            last_speed_next = speed;
            lock_next       = lock_open;
            if (cur_x < target_x)
            begin
                if (lock_open != LOCK_LEFT)
                begin
                    next_x    = (right_sum > {1'b0, target_x}) ? target_x
                                                               : right_sum[COORD_BITS-1:0];
                    lock_next = LOCK_RIGHT;
                end
            end
            else
            begin
                if (lock_open != LOCK_RIGHT)
                begin
                    // Overshoot or underflow clamps to the target
                    next_x    = (speed_c > cur_x || (cur_x - speed_c) < target_x)
                                ? target_x : cur_x - speed_c;
                    lock_next = LOCK_LEFT;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_speed_reg <= '0;
            stop_count_reg <= '0;
            lock_reg       <= LOCK_NONE;
        end
        else if (en)
        begin
            last_speed_reg <= last_speed_next;
            stop_count_reg <= stop_count_next;
            lock_reg       <= lock_next;
        end
    end

endmodule

@@ rtl/pan_window_smoother.sv @@
// Top level of the pan window smoother: request registers and result register.
// Takes one request per clock, sustained while out_ready holds, and raises out_valid
// for a request once it has moved from the input register to the result register:
// the request is captured in an input register, the whole step (history update,
// holding test, speed ramp, stop zone and direction lock) is one combinational
// pass, and the outcome lands in the result register. State advances as each
// request moves into the result register, so consecutive requests see each
// other's effect with no gap. The input side keeps taking requests while a
// result waits, until both registers are full.
module pan_window_smoother #(
    parameter int HISTORY_DEPTH = pws_pkg::HISTORY_DEPTH_DEF,
    parameter int COORD_BITS    = pws_pkg::COORD_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [COORD_BITS-1:0] cur_x,
    input  logic [COORD_BITS-1:0] cur_y,
    input  logic [COORD_BITS-1:0] cur_width,
    input  logic [COORD_BITS-1:0] target_x,
    input  logic [COORD_BITS-1:0] target_width,
    input  logic [COORD_BITS-1:0] target_height,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [COORD_BITS-1:0] next_x,
    output logic [COORD_BITS-1:0] next_y,
    output logic [COORD_BITS-1:0] next_width,
    output logic [COORD_BITS-1:0] next_height
);
    import pws_pkg::*;

    logic                  in_valid_reg;
    logic [COORD_BITS-1:0] cx_reg;
    logic [COORD_BITS-1:0] cy_reg;
    logic [COORD_BITS-1:0] cw_reg;
    logic [COORD_BITS-1:0] tx_reg;
    logic [COORD_BITS-1:0] tw_reg;
    logic [COORD_BITS-1:0] th_reg;

    logic                  out_valid_reg;
    logic [COORD_BITS-1:0] nx_reg;
    logic [COORD_BITS-1:0] ny_reg;
    logic [COORD_BITS-1:0] nw_reg;
    logic [COORD_BITS-1:0] nh_reg;

    logic                  advance;
    logic                  take;
    logic                  holding;
    logic [COORD_BITS-1:0] nx_calc;

    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign take      = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign next_x      = nx_reg;
    assign next_y      = ny_reg;
    assign next_width  = nw_reg;
    assign next_height = nh_reg;

    pws_history #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .COORD_BITS    (COORD_BITS)
    ) u_history (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (advance),
        .target_x     (tx_reg),
        .target_width (tw_reg),
        .holding      (holding)
    );

    pws_pan #(
        .COORD_BITS (COORD_BITS)
    ) u_pan (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (advance),
        .cur_x     (cx_reg),
        .cur_width (cw_reg),
        .target_x  (tx_reg),
        .holding   (holding),
        .next_x    (nx_calc)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cx_reg <= cur_x;
            cy_reg <= cur_y;
            cw_reg <= cur_width;
            tx_reg <= target_x;
            tw_reg <= target_width;
            th_reg <= target_height;
        end
        if (advance)
        begin
            nx_reg <= nx_calc;
            ny_reg <= cy_reg;
            nw_reg <= tw_reg;
            nh_reg <= th_reg;
        end
    end

endmodule
